### hdl/eare_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eare_pkg;

   localparam int LEVEL_WIDTH_DEF = 24;
   localparam int TICK_WIDTH_DEF  = 16;
   localparam int RATIO_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ATTACK_LENGTH     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELEASE_LENGTH    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_LEVEL       = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PEAK_LEVEL        = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_LEVEL         = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ATTACK_TAU_RATIO  = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELEASE_TAU_RATIO = 3'd6;

   localparam int ATTACK_LENGTH_RESET     = 50;
   localparam int RELEASE_LENGTH_RESET    = 200;
   localparam int START_LEVEL_RESET       = 3686;
   localparam int PEAK_LEVEL_RESET        = 4096;
   localparam int END_LEVEL_RESET         = 0;
   localparam int ATTACK_TAU_RATIO_RESET  = 1475;
   localparam int RELEASE_TAU_RATIO_RESET = 1475;

   // x = offset * 2^28 / den; x >= 2^21 always gives exp = 0
   localparam int QUOT_WIDTH    = 21;
   localparam int DIV_CNT_WIDTH = $clog2(QUOT_WIDTH);
   localparam int PRE_SHIFT     = 28 - QUOT_WIDTH;
   localparam int FRAC_WIDTH    = 16;
   localparam int EXP_WIDTH     = 17;
   localparam int Y_WIDTH       = QUOT_WIDTH + EXP_WIDTH - FRAC_WIDTH;
   localparam int K_WIDTH       = Y_WIDTH - FRAC_WIDTH;
   localparam int SHIFT_WIDTH   = 5;
   localparam int SEG_WIDTH     = 4;
   localparam int INTERP_WIDTH  = 12;
   localparam int K_MAX         = 16;

   localparam logic [EXP_WIDTH-1:0] LOG2E_Q16 = 17'd94548;
   localparam logic [EXP_WIDTH-1:0] EXP_ONE   = 17'd65536;

   typedef struct packed {
      logic load;
      logic calc_den;
      logic check;
      logic div_step;
      logic calc_log;
      logic calc_interp;
      logic calc_exp;
      logic calc_mix;
      logic emit;
   } eare_cmd_type;

   typedef struct packed {
      logic skip_div;
   } eare_sts_type;

   // round(65536 * 2^(-idx/16))
   function automatic logic [EXP_WIDTH-1:0] pow2_tab(input logic [SEG_WIDTH:0] idx);
      logic [EXP_WIDTH-1:0] val;
      unique case (idx)
         5'd0:    val = 17'd65536;
         5'd1:    val = 17'd62757;
         5'd2:    val = 17'd60097;
         5'd3:    val = 17'd57549;
         5'd4:    val = 17'd55109;
         5'd5:    val = 17'd52773;
         5'd6:    val = 17'd50535;
         5'd7:    val = 17'd48393;
         5'd8:    val = 17'd46341;
         5'd9:    val = 17'd44376;
         5'd10:   val = 17'd42495;
         5'd11:   val = 17'd40693;
         5'd12:   val = 17'd38968;
         5'd13:   val = 17'd37316;
         5'd14:   val = 17'd35734;
         5'd15:   val = 17'd34219;
         5'd16:   val = 17'd32768;
         default: val = 17'd32768;
      endcase
      return val;
   endfunction

   function automatic logic [INTERP_WIDTH-1:0] pow2_step(input logic [SEG_WIDTH-1:0] idx);
      logic [EXP_WIDTH-1:0] diff;
      diff = pow2_tab({1'b0, idx}) - pow2_tab({1'b0, idx} + 5'd1);
      return diff[INTERP_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

### hdl/eare_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module eare_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output eare_pkg::eare_cmd_type      cmd,
   input  wire eare_pkg::eare_sts_type sts
);
   import eare_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DEN    = 4'd1;
   localparam logic [3:0] ST_CHK    = 4'd2;
   localparam logic [3:0] ST_DIV    = 4'd3;
   localparam logic [3:0] ST_LOG    = 4'd4;
   localparam logic [3:0] ST_INTERP = 4'd5;
   localparam logic [3:0] ST_EXP    = 4'd6;
   localparam logic [3:0] ST_MIX    = 4'd7;
   localparam logic [3:0] ST_OUT    = 4'd8;

   logic [3:0]               state_ff, state_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DEN;
            end
         end
         ST_DEN: begin
            cmd.calc_den = 1'b1;
            state_in     = ST_CHK;
         end
         ST_CHK: begin
            cmd.check = 1'b1;
            if (sts.skip_div) begin
               state_in = ST_MIX;
            end else begin
               state_in = ST_DIV;
               cnt_in   = DIV_CNT_WIDTH'(QUOT_WIDTH - 1);
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_LOG;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_LOG: begin
            cmd.calc_log = 1'b1;
            state_in     = ST_INTERP;
         end
         ST_INTERP: begin
            cmd.calc_interp = 1'b1;
            state_in        = ST_EXP;
         end
         ST_EXP: begin
            cmd.calc_exp = 1'b1;
            state_in     = ST_MIX;
         end
         ST_MIX: begin
            cmd.calc_mix = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_one_cmd: assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("more than one datapath command");
   a_load_den: assert property (@(posedge clock) disable iff (reset) cmd.load |=> cmd.calc_den)
      else $error("accepted request not followed by tau product");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwrites one not yet taken");
   a_div_follow: assert property (@(posedge clock) disable iff (reset)
      (cmd.check && !sts.skip_div) |=> cmd.div_step)
      else $error("divide not started after check");
`endif

endmodule

`default_nettype wire

### hdl/eare_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module eare_dp #(
   parameter int LEVEL_WIDTH = eare_pkg::LEVEL_WIDTH_DEF,
   parameter int TICK_WIDTH  = eare_pkg::TICK_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire eare_pkg::eare_cmd_type            cmd,
   output eare_pkg::eare_sts_type                 sts,
   input  wire logic [TICK_WIDTH-1:0]             attack_length,
   input  wire logic [TICK_WIDTH-1:0]             release_length,
   input  wire logic [LEVEL_WIDTH-1:0]            start_level,
   input  wire logic [LEVEL_WIDTH-1:0]            peak_level,
   input  wire logic [LEVEL_WIDTH-1:0]            end_level,
   input  wire logic [eare_pkg::RATIO_WIDTH-1:0]  attack_tau_ratio,
   input  wire logic [eare_pkg::RATIO_WIDTH-1:0]  release_tau_ratio,
   input  wire logic [TICK_WIDTH-1:0]             tick_index,
   output logic [LEVEL_WIDTH-1:0]                 level,
   output logic                                   in_attack
);
   import eare_pkg::*;

   localparam int DEN_WIDTH       = TICK_WIDTH + RATIO_WIDTH;
   localparam int DIFF_WIDTH      = LEVEL_WIDTH + 1;
   localparam int MIX_WIDTH       = DIFF_WIDTH + EXP_WIDTH + 1;
   localparam int LOG_PROD_WIDTH  = QUOT_WIDTH + EXP_WIDTH;
   localparam int STEP_PROD_WIDTH = 2 * INTERP_WIDTH;
   localparam int OFF_PAD         = DEN_WIDTH - TICK_WIDTH - PRE_SHIFT;

   // request capture
   logic                          tick_attack;
   logic                          phase_ff;
   logic [TICK_WIDTH-1:0]         offset_ff, offset_in;
   logic [TICK_WIDTH-1:0]         len_ff, len_in;
   logic [RATIO_WIDTH-1:0]        ratio_ff, ratio_in;
   logic [LEVEL_WIDTH-1:0]        base_ff, base_in;
   logic signed [DIFF_WIDTH-1:0]  diff_ff, diff_in;
   logic [LEVEL_WIDTH-1:0]        last_ff;

   // divide
   logic [DEN_WIDTH-1:0]          den_ff, den_in;
   logic [DEN_WIDTH-1:0]          scaled_off;
   logic [DEN_WIDTH-1:0]          rem_ff, rem_in;
   logic [DEN_WIDTH:0]            rem_shift, rem_diff;
   logic                          quot_bit;
   logic [QUOT_WIDTH-1:0]         quot_ff;

   // exp
   logic [LOG_PROD_WIDTH-1:0]     log_prod;
   logic [Y_WIDTH-1:0]            y_ff, y_in;
   logic [K_WIDTH-1:0]            k_val;
   logic [SEG_WIDTH-1:0]          seg;
   logic [INTERP_WIDTH-1:0]       frac_t;
   logic [STEP_PROD_WIDTH-1:0]    step_ff, step_in;
   logic [EXP_WIDTH-1:0]          mant;
   logic [EXP_WIDTH-1:0]          exp_ff, exp_in;

   // level
   logic [EXP_WIDTH-1:0]          mult;
   logic signed [MIX_WIDTH-1:0]   mix_ff, mix_in;
   logic [LEVEL_WIDTH-1:0]        level_ff, level_in;
   logic                          in_attack_ff;

   always_comb begin
      tick_attack = tick_index < attack_length;
      offset_in   = tick_attack ? tick_index : tick_index - attack_length;
      len_in      = tick_attack ? attack_length : release_length;
      ratio_in    = tick_attack ? attack_tau_ratio : release_tau_ratio;
      base_in     = tick_attack ? start_level : end_level;
      diff_in     = tick_attack
                  ? DIFF_WIDTH'($signed(peak_level)) - DIFF_WIDTH'($signed(start_level))
                  : DIFF_WIDTH'($signed(last_ff)) - DIFF_WIDTH'($signed(end_level));
   end

   always_comb begin
      den_in = {{RATIO_WIDTH{1'b0}}, len_ff} * {{TICK_WIDTH{1'b0}}, ratio_ff};
      scaled_off = {{OFF_PAD{1'b0}}, offset_ff, {PRE_SHIFT{1'b0}}};
      sts.skip_div = (den_ff == '0) || (scaled_off >= den_ff);
      rem_shift = {rem_ff, 1'b0};
      rem_diff  = rem_shift - {1'b0, den_ff};
      quot_bit  = rem_shift >= {1'b0, den_ff};
      rem_in    = quot_bit ? rem_diff[DEN_WIDTH-1:0] : rem_shift[DEN_WIDTH-1:0];
   end

   always_comb begin
      log_prod = {{EXP_WIDTH{1'b0}}, quot_ff} * {{QUOT_WIDTH{1'b0}}, LOG2E_Q16};
      y_in     = log_prod[FRAC_WIDTH +: Y_WIDTH];
      k_val    = y_ff[Y_WIDTH-1:FRAC_WIDTH];
      seg      = y_ff[FRAC_WIDTH-1 -: SEG_WIDTH];
      frac_t   = y_ff[INTERP_WIDTH-1:0];
      step_in  = {{INTERP_WIDTH{1'b0}}, pow2_step(seg)} * {{INTERP_WIDTH{1'b0}}, frac_t};
      mant     = pow2_tab({1'b0, seg})
               - EXP_WIDTH'(step_ff[STEP_PROD_WIDTH-1:INTERP_WIDTH]);
      exp_in   = (k_val > K_WIDTH'(K_MAX)) ? '0 : mant >> k_val[SHIFT_WIDTH-1:0];
   end

   always_comb begin
      mult     = phase_ff ? EXP_ONE - exp_ff : exp_ff;
      mix_in   = MIX_WIDTH'(diff_ff) * $signed(MIX_WIDTH'(mult));
      level_in = base_ff + mix_ff[FRAC_WIDTH +: LEVEL_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         phase_ff  <= tick_attack;
         offset_ff <= offset_in;
         len_ff    <= len_in;
         ratio_ff  <= ratio_in;
         base_ff   <= base_in;
         diff_ff   <= diff_in;
      end
      if (cmd.calc_den) begin
         den_ff <= den_in;
      end
      if (cmd.check) begin
         rem_ff <= scaled_off;
         exp_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[QUOT_WIDTH-2:0], quot_bit};
      end
      if (cmd.calc_log) begin
         y_ff <= y_in;
      end
      if (cmd.calc_interp) begin
         step_ff <= step_in;
      end
      if (cmd.calc_exp) begin
         exp_ff <= exp_in;
      end
      if (cmd.calc_mix) begin
         mix_ff <= mix_in;
      end
      if (cmd.emit) begin
         level_ff     <= level_in;
         in_attack_ff <= phase_ff;
      end
   end

   // level kept from the most recent attack tick
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= LEVEL_WIDTH'(START_LEVEL_RESET);
      end else if (cmd.emit && phase_ff) begin
         last_ff <= level_in;
      end
   end

   assign level     = level_ff;
   assign in_attack = in_attack_ff;

endmodule

`default_nettype wire

### hdl/exponential_ar_envelope_core.sv
`timescale 1ns / 1ps
`default_nettype none

// A request runs through a 21-step serial divider for tick/tau; the divide is
// skipped when the tau product is zero or the tick offset is past the exp range.
// A new request is accepted only after the last result has been emitted, and a
// result not yet taken at the output holds the next one back.
// Reset: synchronous, active high; the settings registers return to their defaults and
// the kept attack level to the default start level.
module exponential_ar_envelope_core #(
   parameter int   LEVEL_WIDTH = eare_pkg::LEVEL_WIDTH_DEF,
   parameter int   TICK_WIDTH  = eare_pkg::TICK_WIDTH_DEF,
   localparam int  REQ_DATA_WIDTH = ((TICK_WIDTH + 7) / 8) * 8,
   localparam int  RSP_DATA_WIDTH = ((LEVEL_WIDTH + 7) / 8) * 8,
   localparam int  CSR_DATA_WIDTH = (LEVEL_WIDTH > TICK_WIDTH) ? LEVEL_WIDTH : TICK_WIDTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [REQ_DATA_WIDTH-1:0]             req_tdata,   // tick_index
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]                  rsp_tdata,   // level
   output logic                                       rsp_tuser,   // in_attack
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [eare_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]             csr_wdata
);
   import eare_pkg::*;

   logic [TICK_WIDTH-1:0]  attack_length_ff;
   logic [TICK_WIDTH-1:0]  release_length_ff;
   logic [LEVEL_WIDTH-1:0] start_level_ff;
   logic [LEVEL_WIDTH-1:0] peak_level_ff;
   logic [LEVEL_WIDTH-1:0] end_level_ff;
   logic [RATIO_WIDTH-1:0] attack_tau_ratio_ff;
   logic [RATIO_WIDTH-1:0] release_tau_ratio_ff;

   eare_cmd_type           cmd;
   eare_sts_type           sts;
   logic [LEVEL_WIDTH-1:0] level;
   logic                   in_attack;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_length_ff     <= TICK_WIDTH'(ATTACK_LENGTH_RESET);
         release_length_ff    <= TICK_WIDTH'(RELEASE_LENGTH_RESET);
         start_level_ff       <= LEVEL_WIDTH'(START_LEVEL_RESET);
         peak_level_ff        <= LEVEL_WIDTH'(PEAK_LEVEL_RESET);
         end_level_ff         <= LEVEL_WIDTH'(END_LEVEL_RESET);
         attack_tau_ratio_ff  <= RATIO_WIDTH'(ATTACK_TAU_RATIO_RESET);
         release_tau_ratio_ff <= RATIO_WIDTH'(RELEASE_TAU_RATIO_RESET);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ATTACK_LENGTH:     attack_length_ff     <= csr_wdata[TICK_WIDTH-1:0];
            CSR_RELEASE_LENGTH:    release_length_ff    <= csr_wdata[TICK_WIDTH-1:0];
            CSR_START_LEVEL:       start_level_ff       <= csr_wdata[LEVEL_WIDTH-1:0];
            CSR_PEAK_LEVEL:        peak_level_ff        <= csr_wdata[LEVEL_WIDTH-1:0];
            CSR_END_LEVEL:         end_level_ff         <= csr_wdata[LEVEL_WIDTH-1:0];
            CSR_ATTACK_TAU_RATIO:  attack_tau_ratio_ff  <= csr_wdata[RATIO_WIDTH-1:0];
            CSR_RELEASE_TAU_RATIO: release_tau_ratio_ff <= csr_wdata[RATIO_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   eare_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   eare_dp #(
      .LEVEL_WIDTH (LEVEL_WIDTH),
      .TICK_WIDTH  (TICK_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .attack_length     (attack_length_ff),
      .release_length    (release_length_ff),
      .start_level       (start_level_ff),
      .peak_level        (peak_level_ff),
      .end_level         (end_level_ff),
      .attack_tau_ratio  (attack_tau_ratio_ff),
      .release_tau_ratio (release_tau_ratio_ff),
      .tick_index        (req_tdata[TICK_WIDTH-1:0]),
      .level             (level),
      .in_attack         (in_attack)
   );

   assign rsp_tdata = RSP_DATA_WIDTH'(level);
   assign rsp_tuser = in_attack;

endmodule

`default_nettype wire

### tb/exponential_ar_envelope_core_test.sv
`timescale 1ns / 1ps

module exponential_ar_envelope_core_test;
   import eare_pkg::*;

   typedef struct packed {
      logic signed [23:0] level;
      logic               in_attack;
   } envelope_type;

   localparam int QUIET_LIMIT = 2000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [15:0]                req_tdata = '0;   // tick_index
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [23:0]                rsp_tdata;        // level
   logic                       rsp_tuser;        // in_attack
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [23:0]                csr_wdata = '0;

   exponential_ar_envelope_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // 65536 * 2^(-i/16)
   logic [16:0] pow2_seg [0:16] = '{
      17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
      17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
      17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
   };

   // predictor state
   logic [15:0]        m_attack_len;
   logic [15:0]        m_release_len;
   logic [15:0]        m_attack_ratio;
   logic [15:0]        m_release_ratio;
   logic signed [23:0] m_start;
   logic signed [23:0] m_peak;
   logic signed [23:0] m_end;
   logic signed [23:0] m_last;

   logic [15:0]  tick_queue [$];
   envelope_type level_queue [$];
   envelope_type want;

   logic        req_taken = 1'b0;
   logic        rsp_taken = 1'b0;
   logic        csr_taken = 1'b0;
   logic        idle_on = 1'b0;
   int          req_wait = 0;
   int          rsp_hold = 0;
   int          quiet_cycles = 0;

   int          error_count = 0;
   int          requests_sent = 0;
   int          results_checked = 0;
   int          attack_results = 0;
   int          register_writes = 0;
   int          settings_used = 1;

   int unsigned cfg_attack = ATTACK_LENGTH_RESET;
   int unsigned cfg_release = RELEASE_LENGTH_RESET;
   int unsigned cfg_release_ratio = RELEASE_TAU_RATIO_RESET;

   // exp(-offset / (len * ratio / 4096)) in Q0.16
   function automatic logic [16:0] decay_factor(input logic [15:0] offset,
                                                input logic [15:0] len,
                                                input logic [15:0] ratio);
      logic [31:0] den;
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] m;
      logic [15:0] frac;
      den = len * ratio;
      if (den == 0) return '0;
      x = {20'd0, offset, 28'd0} / {32'd0, den};
      if (x > 64'd1572864) return '0;
      y = (x * 64'd94548) >> 16;
      if (y[63:16] > 16) return '0;
      frac = y[15:0];
      m = pow2_seg[frac[15:12]]
          - (((pow2_seg[frac[15:12]] - pow2_seg[frac[15:12] + 1]) * frac[11:0]) >> 12);
      m = m >> y[63:16];
      return m[16:0];
   endfunction

   function automatic envelope_type next_envelope(input logic [15:0] tick);
      logic [16:0]  e;
      longint       weight;
      longint       acc;
      envelope_type res;
      if (tick < m_attack_len) begin
         e = decay_factor(tick, m_attack_len, m_attack_ratio);
         weight = 65536 - e;
         acc = longint'(m_start) + (((longint'(m_peak) - longint'(m_start)) * weight) >>> 16);
         m_last = acc[23:0];
         res.in_attack = 1'b1;
      end else begin
         e = decay_factor(tick - m_attack_len, m_release_len, m_release_ratio);
         weight = e;
         acc = longint'(m_end) + (((longint'(m_last) - longint'(m_end)) * weight) >>> 16);
         res.in_attack = 1'b0;
      end
      res.level = acc[23:0];
      return res;
   endfunction

   function automatic void store_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                          input logic [23:0] value);
      case (idx)
         CSR_ATTACK_LENGTH:     m_attack_len = value[15:0];
         CSR_RELEASE_LENGTH:    m_release_len = value[15:0];
         CSR_START_LEVEL:       m_start = value;
         CSR_PEAK_LEVEL:        m_peak = value;
         CSR_END_LEVEL:         m_end = value;
         CSR_ATTACK_TAU_RATIO:  m_attack_ratio = value[15:0];
         CSR_RELEASE_TAU_RATIO: m_release_ratio = value[15:0];
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint exp_val);
      error_count++;
      $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, exp_val);
   endtask

   function automatic int draw_wait();
      return idle_on ? $urandom_range(0, 15) : 0;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_wait = 0;
      end else if (!req_tvalid || req_taken) begin
         if (req_wait != 0) begin
            req_wait = req_wait - 1;
            req_tvalid <= 1'b0;
         end else if (tick_queue.size() != 0) begin
            req_tdata <= tick_queue.pop_front();
            req_tvalid <= 1'b1;
            req_wait = draw_wait();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_taken) begin
            rsp_hold = draw_wait();
         end else if (rsp_hold != 0) begin
            rsp_hold = rsp_hold - 1;
         end
         rsp_tready <= (rsp_hold == 0);
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
         csr_taken <= 1'b0;
         quiet_cycles <= 0;
         m_attack_len = 16'(ATTACK_LENGTH_RESET);
         m_release_len = 16'(RELEASE_LENGTH_RESET);
         m_start = 24'(START_LEVEL_RESET);
         m_peak = 24'(PEAK_LEVEL_RESET);
         m_end = 24'(END_LEVEL_RESET);
         m_attack_ratio = 16'(ATTACK_TAU_RATIO_RESET);
         m_release_ratio = 16'(RELEASE_TAU_RATIO_RESET);
         m_last = 24'(START_LEVEL_RESET);
      end else begin
         req_taken <= req_tvalid && req_tready;
         rsp_taken <= rsp_tvalid && rsp_tready;
         csr_taken <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) begin
            store_register(csr_index, csr_wdata);
            register_writes++;
         end
         if (req_tvalid && req_tready) begin
            level_queue.push_back(next_envelope(req_tdata));
            requests_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (level_queue.size() == 0) begin
               report_mismatch("level with no request outstanding", $signed(rsp_tdata), 0);
            end else begin
               want = level_queue.pop_front();
               results_checked++;
               if (want.in_attack) attack_results++;
               if (rsp_tdata !== want.level)
                  report_mismatch("level", $signed(rsp_tdata), $signed(want.level));
               if (rsp_tuser !== want.in_attack)
                  report_mismatch("in_attack", rsp_tuser, want.in_attack);
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      do @(posedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("stalled with %0d results outstanding", level_queue.size());
      $display("Verification failed");
      $finish;
   end

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [23:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int unsigned al, input int unsigned rl,
                            input logic [23:0] sl, input logic [23:0] pl,
                            input logic [23:0] el, input int unsigned ar,
                            input int unsigned rr);
      cfg_attack = al % 65536;
      cfg_release = rl % 65536;
      cfg_release_ratio = rr % 65536;
      settings_used++;
      // upper bits of the narrow registers are junk on purpose
      write_register(CSR_ATTACK_LENGTH, {8'($urandom), 16'(al)});
      write_register(CSR_RELEASE_LENGTH, {8'($urandom), 16'(rl)});
      write_register(CSR_START_LEVEL, sl);
      write_register(CSR_PEAK_LEVEL, pl);
      write_register(CSR_END_LEVEL, el);
      write_register(CSR_ATTACK_TAU_RATIO, {8'($urandom), 16'(ar)});
      write_register(CSR_RELEASE_TAU_RATIO, {8'($urandom), 16'(rr)});
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (tick_queue.size() != 0 || req_tvalid || level_queue.size() != 0);
   endtask

   function automatic int unsigned pick_length();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 65535;
         2, 3:    return $urandom_range(0, 65535);
         default: return $urandom_range(1, 300);
      endcase
   endfunction

   function automatic int unsigned pick_ratio();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 65535;
         2:       return $urandom_range(0, 65535);
         default: return $urandom_range(200, 6000);
      endcase
   endfunction

   function automatic logic [23:0] pick_level();
      case ($urandom_range(0, 5))
         0:       return 24'h800000;
         1:       return 24'h7FFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   // mostly note-like runs: ticks climbing from zero through attack into release
   task automatic queue_random(input int count);
      int          added;
      int unsigned tick;
      int unsigned step;
      int unsigned tau_r;
      added = 0;
      tau_r = (cfg_release * cfg_release_ratio) >> 12;
      while (added < count) begin
         if ($urandom_range(0, 9) < 7) begin
            tick = 0;
            for (int j = $urandom_range(6, 40); j > 0 && tick <= 65535 && added < count; j--) begin
               tick_queue.push_back(16'(tick));
               added++;
               if (tick < cfg_attack) step = $urandom_range(1, 1 + cfg_attack / 8);
               else step = $urandom_range(1, 1 + tau_r / 4);
               tick += step;
            end
         end else begin
            case ($urandom_range(0, 2))
               0:       tick = $urandom_range(0, 65535);
               1:       tick = cfg_attack - 1 + $urandom_range(0, 2);
               default: tick = $urandom_range(0, cfg_attack + 30 * tau_r);
            endcase
            tick_queue.push_back(16'(tick));
            added++;
         end
      end
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // defaults; release first, before any attack
      tick_queue.push_back(16'd60);
      tick_queue.push_back(16'd0);
      tick_queue.push_back(16'd1);
      tick_queue.push_back(16'd25);
      tick_queue.push_back(16'd49);
      tick_queue.push_back(16'd50);
      tick_queue.push_back(16'd51);
      tick_queue.push_back(16'd200);
      tick_queue.push_back(16'd1000);
      tick_queue.push_back(16'd65535);
      wait_idle();

      // zero attack tau and zero release tau, extreme levels
      idle_on = 1'b1;
      configure(100, 0, 24'h800000, 24'h7FFFFF, 24'h800000, 0, 65535);
      tick_queue.push_back(16'd0);
      tick_queue.push_back(16'd99);
      tick_queue.push_back(16'd100);
      tick_queue.push_back(16'd65535);
      wait_idle();

      // no attack phase, longest release
      configure(0, 65535, 24'h7FFFFF, 24'h000000, 24'h800000, 65535, 65535);
      tick_queue.push_back(16'd0);
      tick_queue.push_back(16'd1);
      tick_queue.push_back(16'd32768);
      tick_queue.push_back(16'd65535);
      wait_idle();

      // longest attack, release at zero offset
      configure(65535, 1, 24'h000000, 24'h7FFFFF, 24'h000000, 65535, 1);
      tick_queue.push_back(16'd0);
      tick_queue.push_back(16'd1);
      tick_queue.push_back(16'd65534);
      tick_queue.push_back(16'd65535);

      for (int p = 0; p < 12; p++) begin
         wait_idle();
         idle_on = ($urandom_range(0, 3) != 0);
         configure(pick_length(), pick_length(), pick_level(), pick_level(), pick_level(),
                   pick_ratio(), pick_ratio());
         queue_random(150);
      end

      wait_idle();
      repeat (40) @(posedge clock);
      $display("%0d ticks sent, %0d levels checked (%0d attack, %0d release)",
               requests_sent, results_checked, attack_results,
               results_checked - attack_results);
      $display("%0d register writes over %0d settings, %0d mismatches",
               register_writes, settings_used, error_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
